// ===== src/euclidean_rhythm_generator_macros.svh =====
// Assertion macros shared by the rhythm generator RTL.
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ERG_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ERG_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/erg_pkg.sv =====
`timescale 1ns / 1ps

package erg_pkg;

    // longest pattern; longer requests saturate here
    localparam int MAX_STEPS   = 16;
    // group / step counts and group sizes, 0..MAX_STEPS
    localparam int CNT_W       = $clog2(MAX_STEPS + 1);
    // one group never exceeds the pattern length
    localparam int GRP_W       = MAX_STEPS;
    localparam int BIT_W       = (GRP_W > 1) ? $clog2(GRP_W) : 1;
    // grouping rounds before giving up with an empty pattern
    localparam int ROUND_GUARD = 64;
    localparam int ROUND_W     = $clog2(ROUND_GUARD);
    // stream payload widths
    localparam int IN_FLD_W    = 5;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 16;
    // divider step counter
    localparam int STEP_W      = $clog2(CNT_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DECIDE,
        S_EMIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== src/erg_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module erg_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  erg_pkg::t_div_ctl          i_ctl,
    input  logic [erg_pkg::CNT_W-1:0]  i_numer,
    input  logic [erg_pkg::CNT_W-1:0]  i_denom,   // held stable while busy
    output logic [erg_pkg::CNT_W-1:0]  o_quot,
    output erg_pkg::t_div_stat         o_stat
);

    logic [erg_pkg::CNT_W-1:0]  r_rem;
    logic [erg_pkg::CNT_W-1:0]  r_quo;
    logic [erg_pkg::STEP_W-1:0] r_step;
    logic                       r_busy;
    logic                       r_done;

    logic [erg_pkg::CNT_W:0]    w_trial;
    logic [erg_pkg::CNT_W:0]    w_diff;
    logic                       w_fits;

    assign w_trial = {r_rem, r_quo[erg_pkg::CNT_W-1]};
    assign w_diff  = w_trial - {1'b0, i_denom};
    assign w_fits  = (w_trial >= {1'b0, i_denom});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= erg_pkg::STEP_W'(erg_pkg::CNT_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == erg_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_numer;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[erg_pkg::CNT_W-1:0] : w_trial[erg_pkg::CNT_W-1:0];
            r_quo <= {r_quo[erg_pkg::CNT_W-2:0], w_fits};
        end
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/euclidean_rhythm_generator.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload (low bit up)
// s (in)    in   i_s_tvalid / o_s_tready      i_s_tdata: pattern_length[4:0], pulse_count[9:5]
// m (out)   out  o_m_tvalid / i_m_tready      o_m_tdata: rhythm_bits[15:0]
//
// One item at a time. Each grouping round runs set-up, the bit-serial divider and a
// decision; writing the pattern costs one cycle per emitted step.
// Reset (i_rst_n low, synchronous) idles the sequencer and empties the output register.
// The result sits in an output register; a new item is taken while it waits,
// and only the final load waits on a stalled output.

`include "euclidean_rhythm_generator_macros.svh"

module euclidean_rhythm_generator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [erg_pkg::IN_W-1:0]  i_s_tdata,   // [4:0] pattern_length, [9:5] pulse_count
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [erg_pkg::OUT_W-1:0] o_m_tdata    // [15:0] rhythm_bits
);

    erg_pkg::t_state r_state, n_state;

    // grouping state
    logic [erg_pkg::CNT_W-1:0]   r_len;
    logic [erg_pkg::CNT_W-1:0]   r_cnt1;    // note groups
    logic [erg_pkg::CNT_W-1:0]   r_cnt2;    // rest groups (divider result)
    logic [erg_pkg::CNT_W-1:0]   r_s1;      // note group size
    logic [erg_pkg::CNT_W-1:0]   r_s2;      // rest group size
    logic [erg_pkg::GRP_W-1:0]   r_g1;
    logic [erg_pkg::GRP_W-1:0]   r_g2;
    logic [erg_pkg::ROUND_W-1:0] r_round;

    // write-out state
    logic                        r_sel;     // 0: note groups, 1: trailing rest group
    logic [erg_pkg::CNT_W-1:0]   r_copy;    // groups left, this one included
    logic [erg_pkg::BIT_W-1:0]   r_bit;     // bit of the group, MSB first
    logic [erg_pkg::CNT_W-1:0]   r_pos;
    logic [erg_pkg::OUT_W-1:0]   r_pat;

    // output register
    logic                        r_out_valid;
    logic [erg_pkg::OUT_W-1:0]   r_out_data;

    // control
    logic                        w_accept;
    logic                        w_load_out;
    logic                        w_last_round;
    logic                        w_stop;
    logic                        w_emit_last;
    erg_pkg::t_div_ctl           w_div_ctl;
    erg_pkg::t_div_stat          w_div_stat;
    logic [erg_pkg::CNT_W-1:0]   w_quot;
    logic                        w_grouped;
    logic                        w_div_active;

    // datapath helpers
    logic [erg_pkg::IN_FLD_W-1:0] w_in_len;
    logic [erg_pkg::IN_FLD_W-1:0] w_in_pul;
    logic [erg_pkg::CNT_W-1:0]    w_len;
    logic [erg_pkg::CNT_W-1:0]    w_pul;
    logic [2*erg_pkg::CNT_W-1:0]  w_prod;
    logic [erg_pkg::CNT_W-1:0]    w_numer;
    logic [erg_pkg::GRP_W-1:0]    w_src;

    // ---------------- input clamp ----------------
    assign w_in_len = i_s_tdata[erg_pkg::IN_FLD_W-1:0];
    assign w_in_pul = i_s_tdata[2*erg_pkg::IN_FLD_W-1:erg_pkg::IN_FLD_W];

    always_comb begin
        if (w_in_len == '0) begin
            w_len = erg_pkg::CNT_W'(1);
        end else if (int'(w_in_len) > erg_pkg::MAX_STEPS) begin
            w_len = erg_pkg::CNT_W'(erg_pkg::MAX_STEPS);
        end else begin
            w_len = erg_pkg::CNT_W'(w_in_len);
        end
        if (w_in_pul == '0) begin
            w_pul = erg_pkg::CNT_W'(1);
        end else if (int'(w_in_pul) > int'(w_len)) begin
            w_pul = w_len;
        end else begin
            w_pul = erg_pkg::CNT_W'(w_in_pul);
        end
    end

    // steps left over for rest groups; never negative
    assign w_prod  = r_cnt1 * r_s1;
    assign w_numer = r_len - w_prod[erg_pkg::CNT_W-1:0];

    // ---------------- shared divider ----------------
    erg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_numer (w_numer),
        .i_denom (r_s2),
        .o_quot  (w_quot),
        .o_stat  (w_div_stat)
    );

    // ---------------- sequencer ----------------
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_stop       = (r_cnt2 <= erg_pkg::CNT_W'(1));
    assign w_last_round = (r_round == erg_pkg::ROUND_W'(erg_pkg::ROUND_GUARD - 1));
    assign w_src        = r_sel ? r_g2 : r_g1;
    assign w_emit_last  = (r_bit == '0) && (r_copy == erg_pkg::CNT_W'(1)) &&
                          (r_sel || (r_cnt2 == '0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            erg_pkg::S_IDLE: begin
                if (w_accept) n_state = erg_pkg::S_PREP;
            end
            erg_pkg::S_PREP: begin
                n_state = erg_pkg::S_DIV;
            end
            erg_pkg::S_DIV: begin
                if (w_div_stat.done) n_state = erg_pkg::S_DECIDE;
            end
            erg_pkg::S_DECIDE: begin
                if (w_stop)            n_state = erg_pkg::S_EMIT;
                else if (w_last_round) n_state = erg_pkg::S_FINISH;
                else                   n_state = erg_pkg::S_PREP;
            end
            erg_pkg::S_EMIT: begin
                if (w_emit_last) n_state = erg_pkg::S_FINISH;
            end
            erg_pkg::S_FINISH: begin
                if (w_load_out) n_state = erg_pkg::S_IDLE;
            end
            default: begin
                n_state = erg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            erg_pkg::S_IDLE:   o_s_tready      = 1'b1;
            erg_pkg::S_PREP:   w_div_ctl.start = 1'b1;
            erg_pkg::S_FINISH: w_load_out      = !r_out_valid || i_m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- grouping datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            erg_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_len   <= w_len;
                    r_cnt1  <= w_pul;
                    r_s1    <= erg_pkg::CNT_W'(1);
                    r_s2    <= erg_pkg::CNT_W'(1);
                    r_g1    <= erg_pkg::GRP_W'(1);
                    r_g2    <= '0;
                    r_round <= '0;
                    r_pos   <= '0;
                    r_pat   <= '0;
                end
            end
            erg_pkg::S_DIV: begin
                if (w_div_stat.done) r_cnt2 <= w_quot;
            end
            erg_pkg::S_DECIDE: begin
                if (w_stop) begin
                    r_sel  <= 1'b0;
                    r_copy <= r_cnt1;
                    r_bit  <= erg_pkg::BIT_W'(r_s1 - 1'b1);
                end else begin
                    // rest group appended to note group; rest group swaps when
                    // rest groups no longer outnumber note groups
                    r_g1    <= (r_g1 << r_s2) | r_g2;
                    r_s1    <= r_s1 + r_s2;
                    if (r_cnt2 <= r_cnt1) begin
                        r_g2 <= r_g1;
                        r_s2 <= r_s1;
                    end
                    r_cnt1  <= (r_cnt1 > r_cnt2) ? r_cnt2 : r_cnt1;
                    r_round <= r_round + 1'b1;
                end
            end
            erg_pkg::S_EMIT: begin
                // steps past the output width drop off the shift
                if (w_src[r_bit]) r_pat <= r_pat | (erg_pkg::OUT_W'(1) << r_pos);
                r_pos <= r_pos + 1'b1;
                if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                end else if (r_copy != erg_pkg::CNT_W'(1)) begin
                    r_copy <= r_copy - 1'b1;
                    r_bit  <= erg_pkg::BIT_W'((r_sel ? r_s2 : r_s1) - 1'b1);
                end else begin
                    r_sel  <= 1'b1;
                    r_copy <= erg_pkg::CNT_W'(1);
                    r_bit  <= erg_pkg::BIT_W'(r_s2 - 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) r_out_data <= r_pat;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- checks ----------------
    assign w_grouped    = (r_state == erg_pkg::S_DECIDE) || (r_state == erg_pkg::S_EMIT);
    assign w_div_active = w_div_stat.busy || w_div_stat.done;

    `ERG_CHECK_NEXT(a_busy_after_accept, w_accept, !o_s_tready, "ready right after accept")
    `ERG_CHECK(a_div_denom, r_state == erg_pkg::S_DIV, r_s2 != '0, "zero rest group size")
    `ERG_CHECK(a_notes_left, w_grouped, r_cnt1 != '0 && r_s1 <= r_len, "note groups lost")
    `ERG_CHECK(a_div_owner, w_div_active, r_state == erg_pkg::S_DIV, "divider active late")

endmodule
